/* src/mbr_pkg.sv */
package mbr_pkg;

  localparam int STORE_BYTES    = 64;
  localparam int MAX_FIELD_BITS = 32;

  localparam int MODE_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int HELD_W   = 10;

  localparam int RING_BITS = STORE_BYTES * BYTE_W;
  localparam int NBANK     = 8;
  localparam int BANK_W    = $clog2(NBANK);
  localparam int ROWS      = STORE_BYTES / NBANK;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int BADDR_W   = $clog2(STORE_BYTES);
  localparam int POS_W     = $clog2(RING_BITS);
  localparam int CNT_W     = $clog2(RING_BITS + 1);
  localparam int ADV_W     = $clog2(VALUE_W + 2);

  // bytes needed to cover a full-width field starting at any bit of a byte
  localparam int WIN_BYTES = (VALUE_W + BYTE_W - 1 + BYTE_W - 1) / BYTE_W;
  localparam int WIN_W     = WIN_BYTES * BYTE_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 3'd0,
    MODE_READ_U = 3'd1,
    MODE_READ_S = 3'd2,
    MODE_UNARY  = 3'd3,
    MODE_ALIGN  = 3'd4,
    MODE_SKIP   = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_UNDER = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [BYTE_W-1:0]  byte_in;
    logic [COUNT_W-1:0] count;
    logic               stop_bit;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
    logic               wr_en;
    logic [BADDR_W-1:0] wr_addr;
    logic [POS_W-1:0]   pos_nxt;
    logic [CNT_W-1:0]   cnt_nxt;
  } exec_t;

endpackage

/* src/mbr_in_if.sv */
interface mbr_in_if;
  import mbr_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [BYTE_W-1:0]  byte_in;
  logic [COUNT_W-1:0] count;
  logic               stop_bit;

  modport source (output valid, output mode, output byte_in, output count, output stop_bit,
                  input ready);
  modport sink (input valid, input mode, input byte_in, input count, input stop_bit,
                output ready);
endinterface

/* src/mbr_out_if.sv */
interface mbr_out_if;
  import mbr_pkg::*;

  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  value;
  logic [STATUS_W-1:0] status;
  logic [HELD_W-1:0]   bits_held;

  modport source (output valid, output value, output status, output bits_held, input ready);
  modport sink (input valid, input value, input status, input bits_held, output ready);
endinterface

/* src/mbr_store.sv */
module mbr_store (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [mbr_pkg::BADDR_W-1:0]  wr_addr,
  input  logic [mbr_pkg::BYTE_W-1:0]   wr_data,
  input  logic [mbr_pkg::BADDR_W-1:0]  rd_addr,
  output logic [mbr_pkg::WIN_W-1:0]    window
);
  import mbr_pkg::*;

  logic [BYTE_W-1:0] bank_mem [NBANK][ROWS];
  logic [BYTE_W-1:0] bank_q_r [NBANK];
  logic [ROW_W-1:0]  bank_row [NBANK];
  logic [BANK_W-1:0] rd_bank_r;
  logic [BANK_W-1:0] wr_bank;
  logic [BANK_W-1:0] rd_bank;
  logic [ROW_W-1:0]  wr_row;
  logic [ROW_W-1:0]  rd_row;
  logic [ROW_W-1:0]  rd_row_inc;

  // rd_addr is the byte under the read position in the next cycle
  assign wr_bank = wr_addr[BANK_W-1:0];
  assign wr_row  = ROW_W'(wr_addr >> BANK_W);
  assign rd_bank = rd_addr[BANK_W-1:0];
  assign rd_row  = ROW_W'(rd_addr >> BANK_W);

  // banks below the start bank hold the bytes that spill into the next row
  always_comb begin
    rd_row_inc = (rd_row == ROW_W'(ROWS - 1)) ? '0 : rd_row + 1'b1;
    for (int b = 0; b < NBANK; b++) begin
      bank_row[b] = (BANK_W'(b) >= rd_bank) ? rd_row : rd_row_inc;
    end
  end

  // a byte written in this cycle is forwarded into the window
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bank_mem[wr_bank][wr_row] <= wr_data;
    end
    for (int b = 0; b < NBANK; b++) begin
      if (wr_en && wr_bank == BANK_W'(b) && wr_row == bank_row[b]) begin
        bank_q_r[b] <= wr_data;
      end else begin
        bank_q_r[b] <= bank_mem[b][bank_row[b]];
      end
    end
    rd_bank_r <= rd_bank;
  end

  always_comb begin
    for (int k = 0; k < WIN_BYTES; k++) begin
      window[WIN_W-1-k*BYTE_W -: BYTE_W] = bank_q_r[BANK_W'(rd_bank_r + BANK_W'(k))];
    end
  end

endmodule

/* src/mbr_exec.sv */
module mbr_exec (
  input  mbr_pkg::item_t               item,
  input  logic [mbr_pkg::POS_W-1:0]    pos,
  input  logic [mbr_pkg::CNT_W-1:0]    held,
  input  logic [mbr_pkg::WIN_W-1:0]    window,
  output mbr_pkg::exec_t               res
);
  import mbr_pkg::*;

  mode_t              md;
  logic [COUNT_W-1:0] n_sat;
  logic [COUNT_W-1:0] lead;
  logic [2:0]         off;
  logic [2:0]         n_al;
  logic [WIN_W-1:0]   win_sh;
  logic [VALUE_W-1:0] top;
  logic [VALUE_W-1:0] rd_u;
  logic [VALUE_W-1:0] rd_s;
  logic [VALUE_W-1:0] al_val;
  logic [VALUE_W-1:0] lmask;
  logic [VALUE_W-1:0] vmask;
  logic [VALUE_W-1:0] match;
  logic               found;
  logic               fits;
  logic               al_fits;
  logic               full;
  logic [ADV_W-1:0]   adv;
  logic [POS_W:0]     pos_sum;
  logic [POS_W:0]     wr_sum;

  always_comb begin
    md      = mode_t'(item.mode);
    n_sat   = (item.count > COUNT_W'(MAX_FIELD_BITS)) ? COUNT_W'(MAX_FIELD_BITS) : item.count;
    off     = pos[2:0];
    n_al    = 3'd0 - off;
    win_sh  = window << off;
    top     = win_sh[WIN_W-1 -: VALUE_W];
    rd_u    = top >> (COUNT_W'(VALUE_W) - n_sat);
    rd_s    = (n_sat == '0) ? '0 : $unsigned($signed(top) >>> (COUNT_W'(VALUE_W) - n_sat));
    al_val  = top >> (COUNT_W'(VALUE_W) - COUNT_W'(n_al));
    fits    = CNT_W'(n_sat) <= held;
    al_fits = CNT_W'(n_al) <= held;
    full    = held > CNT_W'(RING_BITS - BYTE_W);

    // unary: first bit equal to the stop bit, inside both the limit and the buffered bits
    lmask = ~({VALUE_W{1'b1}} >> n_sat);
    vmask = (held >= CNT_W'(VALUE_W)) ? '1 : ~({VALUE_W{1'b1}} >> held);
    match = ~(top ^ {VALUE_W{item.stop_bit}}) & lmask & vmask;
    found = |match;
    lead  = '0;
    for (int i = 0; i < VALUE_W; i++) begin
      if (match[i]) begin
        lead = COUNT_W'(VALUE_W - 1 - i);
      end
    end

    wr_sum = {1'b0, pos} + (POS_W + 1)'(held);
    if (wr_sum >= (POS_W + 1)'(RING_BITS)) begin
      wr_sum = wr_sum - (POS_W + 1)'(RING_BITS);
    end

    res.value   = '0;
    res.status  = STAT_DONE;
    res.wr_en   = 1'b0;
    res.wr_addr = wr_sum[POS_W-1:3];
    adv         = '0;

    unique case (md) inside
      MODE_LOAD: begin
        if (full) begin
          res.status = STAT_FULL;
        end else begin
          res.wr_en = 1'b1;
        end
      end
      MODE_READ_U, MODE_READ_S: begin
        if (!fits) begin
          res.status = STAT_UNDER;
        end else begin
          res.value = (md == MODE_READ_S) ? rd_s : rd_u;
          adv       = ADV_W'(n_sat);
        end
      end
      MODE_UNARY: begin
        if (found) begin
          res.value = VALUE_W'(lead);
          adv       = ADV_W'(lead) + 1'b1;
        end else if (fits) begin
          res.value = VALUE_W'(n_sat);
          adv       = ADV_W'(n_sat);
        end else begin
          res.status = STAT_UNDER;
        end
      end
      MODE_ALIGN: begin
        if (!al_fits) begin
          res.status = STAT_UNDER;
        end else begin
          res.value = al_val;
          adv       = ADV_W'(n_al);
        end
      end
      MODE_SKIP: begin
        if (!fits) begin
          res.status = STAT_UNDER;
        end else begin
          adv = ADV_W'(n_sat);
        end
      end
      default: begin
      end
    endcase

    pos_sum = {1'b0, pos} + (POS_W + 1)'(adv);
    if (pos_sum >= (POS_W + 1)'(RING_BITS)) begin
      pos_sum = pos_sum - (POS_W + 1)'(RING_BITS);
    end
    res.pos_nxt = pos_sum[POS_W-1:0];
    res.cnt_nxt = res.wr_en ? held + CNT_W'(BYTE_W) : held - CNT_W'(adv);
  end

endmodule

/* src/msb_first_bitstream_reader.sv */
// MSB-first bit reader over a 64-byte ring. Each beat on in_ch carries one command (load a byte,
// read 0..32 bits unsigned or sign-extended, unary count, align, skip) and yields exactly one
// beat on out_ch with the value, a status (done, underflow, store full) and the bits held after
// the command. Throughput is one command per cycle unless out_ch holds off ready; each command
// passes the input register, then the result register. The whole command resolves in one pass
// of a 40-bit barrel shift and a 32-bit leading-match detector; the store is eight byte banks
// read at the edge that sets the read position, so the five bytes under it are registered and
// ready in the next cycle. Refused commands leave the read position and the buffered count
// untouched. No clearing pass is needed after reset.
module msb_first_bitstream_reader (
  input logic      clk,
  input logic      rst_n,
  mbr_in_if.sink   in_ch,
  mbr_out_if.source out_ch
);
  import mbr_pkg::*;

  item_t              item_r;
  logic               item_vld_r;
  logic               item_vld_nxt;
  logic               out_vld_r;
  logic               out_vld_nxt;
  logic [VALUE_W-1:0] out_value_r;
  status_t            out_status_r;
  logic [HELD_W-1:0]  out_held_r;
  logic [POS_W-1:0]   pos_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               in_accept;
  logic               fire;
  logic [BADDR_W-1:0] rd_addr_nxt;
  logic [WIN_W-1:0]   window;
  exec_t              ex;

  assign fire        = item_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !item_vld_r || fire;
  assign in_accept   = in_ch.valid && in_ch.ready;

  assign rd_addr_nxt = !rst_n ? '0 :
                       fire   ? ex.pos_nxt[POS_W-1:3] : pos_r[POS_W-1:3];

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (in_accept) begin
      item_vld_nxt = 1'b1;
    end else if (fire) begin
      item_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  mbr_store u_store (
    .clk     (clk),
    .wr_en   (fire && ex.wr_en),
    .wr_addr (ex.wr_addr),
    .wr_data (item_r.byte_in),
    .rd_addr (rd_addr_nxt),
    .window  (window)
  );

  mbr_exec u_exec (
    .item   (item_r),
    .pos    (pos_r),
    .held   (cnt_r),
    .window (window),
    .res    (ex)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      pos_r      <= '0;
      cnt_r      <= '0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (fire) begin
        pos_r <= ex.pos_nxt;
        cnt_r <= ex.cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r.mode     <= in_ch.mode;
      item_r.byte_in  <= in_ch.byte_in;
      item_r.count    <= in_ch.count;
      item_r.stop_bit <= in_ch.stop_bit;
    end
    if (fire) begin
      out_value_r  <= ex.value;
      out_status_r <= ex.status;
      out_held_r   <= ex.cnt_nxt[HELD_W-1:0];
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.value     = out_value_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.bits_held = out_held_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(RING_BITS))
    else $error("buffered bit count beyond ring size");

  a_load_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ex.wr_en) |=> (cnt_r == $past(cnt_r) + CNT_W'(BYTE_W)))
    else $error("accepted load did not add one byte");

  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ex.status != STAT_DONE) |=> ($stable(pos_r) && $stable(cnt_r)))
    else $error("refused command changed state");

  a_held_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_held_r == cnt_r[HELD_W-1:0]))
    else $error("reported bits held disagrees with state");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import mbr_pkg::*;

  localparam logic [MODE_W-1:0] MODE_RSVD_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD_7 = 3'd7;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int RX_HOLD_CYCLES = 300;

  typedef struct {
    logic [VALUE_W-1:0] value;
    status_t            status;
    logic [HELD_W-1:0]  held;
  } reader_result_t;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mbr_in_if  in_ch ();
  mbr_out_if out_ch ();

  msb_first_bitstream_reader dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // shadow copy of the reader: ring contents, read pointer and fill level
  logic [BYTE_W-1:0] ring_mem [STORE_BYTES];
  int unsigned       rd_bit    = 0;
  int unsigned       held_bits = 0;

  reader_result_t pending_results [$];

  int unsigned err_cnt    = 0;
  int unsigned cmd_cnt    = 0;
  int unsigned result_cnt = 0;
  int unsigned under_cnt  = 0;
  int unsigned full_cnt   = 0;
  int unsigned wrap_cnt   = 0;
  int unsigned cycle_cnt  = 0;

  int unsigned tx_idle_pct  = 33;
  int unsigned rx_idle_pct  = 33;
  int unsigned rx_hold_req  = 0;
  int unsigned rx_hold_seen = 0;
  int unsigned rx_hold_left = 0;

  function automatic logic ring_bit(int unsigned off);
    int unsigned p;
    p = (rd_bit + off) % RING_BITS;
    return ring_mem[p >> 3][7 - (p % 8)];
  endfunction

  function automatic logic [VALUE_W-1:0] peek_field(int unsigned n);
    logic [VALUE_W-1:0] v;
    v = '0;
    for (int unsigned i = 0; i < n; i++) v = {v[VALUE_W-2:0], ring_bit(i)};
    return v;
  endfunction

  function automatic void consume_bits(int unsigned n);
    if (rd_bit + n >= RING_BITS) wrap_cnt++;
    rd_bit    = (rd_bit + n) % RING_BITS;
    held_bits = held_bits - n;
  endfunction

  function automatic reader_result_t predict_reader(logic [MODE_W-1:0] mode,
                                                    logic [BYTE_W-1:0] byte_in,
                                                    logic [COUNT_W-1:0] count,
                                                    logic stop_bit);
    reader_result_t r;
    int unsigned    n;
    int unsigned    i;
    bit             found;
    r.value  = '0;
    r.status = STAT_DONE;
    n = (count > MAX_FIELD_BITS) ? MAX_FIELD_BITS : count;
    case (mode)
      MODE_LOAD: begin
        if (held_bits + BYTE_W > RING_BITS) begin
          r.status = STAT_FULL;
        end else begin
          ring_mem[((rd_bit + held_bits) % RING_BITS) >> 3] = byte_in;
          held_bits = held_bits + BYTE_W;
        end
      end
      MODE_READ_U, MODE_READ_S: begin
        if (n > held_bits) begin
          r.status = STAT_UNDER;
        end else begin
          r.value = peek_field(n);
          if (mode == MODE_READ_S && n > 0 && n < VALUE_W && r.value[n-1])
            r.value = r.value | ~((32'd1 << n) - 32'd1);
          consume_bits(n);
        end
      end
      MODE_UNARY: begin
        found = 1'b0;
        i     = 0;
        while (i < n && i < held_bits && !found) begin
          if (ring_bit(i) == stop_bit) found = 1'b1;
          else i++;
        end
        if (found) begin
          r.value = i;
          consume_bits(i + 1);
        end else if (i == n) begin
          r.value = n;
          consume_bits(n);
        end else begin
          r.status = STAT_UNDER;
        end
      end
      MODE_ALIGN: begin
        i = (BYTE_W - (rd_bit % BYTE_W)) % BYTE_W;
        if (i > held_bits) begin
          r.status = STAT_UNDER;
        end else begin
          r.value = peek_field(i);
          consume_bits(i);
        end
      end
      MODE_SKIP: begin
        if (n > held_bits) r.status = STAT_UNDER;
        else consume_bits(n);
      end
      default: ;
    endcase
    if (r.status == STAT_UNDER) under_cnt++;
    if (r.status == STAT_FULL) full_cnt++;
    r.held = HELD_W'(held_bits);
    return r;
  endfunction

  task automatic send_cmd(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] byte_in = '0,
                          logic [COUNT_W-1:0] count = '0, logic stop_bit = 1'b0);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.byte_in  <= byte_in;
    in_ch.count    <= count;
    in_ch.stop_bit <= stop_bit;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(predict_reader(mode, byte_in, count, stop_bit));
    cmd_cnt++;
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic fill_store();
    while (held_bits + BYTE_W <= RING_BITS) send_cmd(MODE_LOAD, BYTE_W'($urandom));
    repeat (2) send_cmd(MODE_LOAD, BYTE_W'($urandom));
  endtask

  task automatic send_random_cmd();
    int unsigned       load_pct;
    int unsigned       pick;
    logic [COUNT_W-1:0] cnt;
    logic [BYTE_W-1:0]  b;
    logic [MODE_W-1:0]  mode;
    load_pct = (held_bits < 48) ? 65 : (held_bits > 440) ? 25 : 42;
    if ($urandom_range(99) < load_pct) begin
      // constant bytes give long runs for unary counts
      case ($urandom_range(9))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = BYTE_W'($urandom);
      endcase
      send_cmd(MODE_LOAD, b, COUNT_W'($urandom), 1'($urandom));
    end else begin
      cnt  = COUNT_W'(($urandom_range(9) == 0) ? $urandom_range(63, 33) : $urandom_range(32));
      pick = $urandom_range(99);
      if (pick < 22) mode = MODE_READ_U;
      else if (pick < 42) mode = MODE_READ_S;
      else if (pick < 64) mode = MODE_UNARY;
      else if (pick < 76) mode = MODE_ALIGN;
      else if (pick < 97) mode = MODE_SKIP;
      else if (pick < 99) mode = MODE_RSVD_6;
      else mode = MODE_RSVD_7;
      send_cmd(mode, BYTE_W'($urandom), cnt, 1'($urandom));
    end
  endtask

  task automatic test_directed();
    send_cmd(MODE_READ_U, 8'h00, 6'd0, 1'b0);
    send_cmd(MODE_READ_S, 8'h00, 6'd1, 1'b0);
    send_cmd(MODE_UNARY, 8'h00, 6'd0, 1'b1);
    send_cmd(MODE_UNARY, 8'h00, 6'd5, 1'b0);
    send_cmd(MODE_ALIGN);
    send_cmd(MODE_SKIP, 8'h00, 6'd63, 1'b0);
    send_cmd(MODE_RSVD_6, 8'hFF, 6'd63, 1'b1);
    send_cmd(MODE_RSVD_7, 8'h00, 6'd0, 1'b0);
    send_cmd(MODE_LOAD, 8'hA5);
    send_cmd(MODE_LOAD, 8'hFF);
    send_cmd(MODE_LOAD, 8'h00);
    send_cmd(MODE_LOAD, 8'h80);
    send_cmd(MODE_LOAD, 8'h7F);
    send_cmd(MODE_READ_U, 8'h00, 6'd3, 1'b0);
    send_cmd(MODE_READ_S, 8'h00, 6'd5, 1'b0);
    send_cmd(MODE_READ_S, 8'h00, 6'd4, 1'b0);
    send_cmd(MODE_ALIGN);
    send_cmd(MODE_UNARY, 8'h00, 6'd63, 1'b1);
    send_cmd(MODE_READ_S, 8'h00, 6'd40, 1'b0);
    send_cmd(MODE_LOAD, 8'hC3);
    send_cmd(MODE_LOAD, 8'h5A);
    send_cmd(MODE_LOAD, 8'h01);
    send_cmd(MODE_LOAD, 8'hE7);
    send_cmd(MODE_READ_S, 8'h00, 6'd0, 1'b0);
    send_cmd(MODE_READ_U, 8'h00, 6'd32, 1'b0);
    send_cmd(MODE_UNARY, 8'h00, 6'd4, 1'b0);
    send_cmd(MODE_SKIP, 8'h00, 6'd63, 1'b0);
  endtask

  task automatic test_store_full();
    fill_store();
    repeat (10) send_cmd(MODE_READ_S, BYTE_W'($urandom), 6'd32, 1'($urandom));
    repeat (30) send_cmd(MODE_LOAD, BYTE_W'($urandom));
    repeat (12) send_cmd(MODE_READ_U, BYTE_W'($urandom), 6'd32, 1'($urandom));
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    repeat (n_items) begin
      if ($urandom_range(199) == 0) fill_store();
      else send_random_cmd();
    end
  endtask

  task automatic test_no_idle_stretch(int unsigned n_items);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(n_items);
    tx_idle_pct = 33;
    rx_idle_pct = 33;
  endtask

  task automatic test_backpressure(int unsigned n_items);
    rx_hold_req++;
    tx_idle_pct = 0;
    test_random_traffic(n_items);
    tx_idle_pct = 33;
  endtask

  always @(posedge clk) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen = rx_hold_req;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left != 0) begin
      out_ch.ready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic report_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: MISMATCH %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    reader_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_cnt++;
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result beat, value %0h status %0d bits_held %0d",
                 $time, out_ch.value, out_ch.status, out_ch.bits_held);
      end else begin
        want = pending_results.pop_front();
        report_field("value", want.value, out_ch.value);
        report_field("status", VALUE_W'(want.status), VALUE_W'(out_ch.status));
        report_field("bits_held", VALUE_W'(want.held), VALUE_W'(out_ch.bits_held));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("msb_first_bitstream_reader verification failed");
      $finish;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.mode     <= MODE_LOAD;
    in_ch.byte_in  <= '0;
    in_ch.count    <= '0;
    in_ch.stop_bit <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    wait_all_results();
    test_store_full();
    wait_all_results();
    test_random_traffic(400);
    test_no_idle_stretch(250);
    test_backpressure(60);
    wait_all_results();
    test_random_traffic(330);
    wait_all_results();

    if (pending_results.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    $display("Covered %0d commands and %0d result beats: %0d underflow, %0d store-full refusals,",
             cmd_cnt, result_cnt, under_cnt, full_cnt);
    $display("read position wrapped the %0d-byte ring %0d times; %0d errors",
             STORE_BYTES, wrap_cnt, err_cnt);
    if (err_cnt == 0) $display("msb_first_bitstream_reader verification clean");
    else $display("msb_first_bitstream_reader verification failed");
    $finish;
  end

endmodule

/* filelist.f */
src/mbr_pkg.sv
src/mbr_in_if.sv
src/mbr_out_if.sv
src/mbr_store.sv
src/mbr_exec.sv
src/msb_first_bitstream_reader.sv
tb/tb_top.sv
